FILE: rtl/core/iqs_pkg.sv
package iqs_pkg;

    localparam int MaxElements = 64;
    localparam int IdxW = $clog2(MaxElements);
    localparam int CntW = IdxW + 1;
    localparam int ValW = 32;
    localparam int SwapW = 24;
    localparam int CallW = 14;

    localparam logic [SwapW-1:0] SwapMax = '1;
    localparam logic [CallW-1:0] CallMax = '1;

    localparam logic [0:0] CfgScheme = 1'd0;
    localparam logic [0:0] CfgPivot = 1'd1;

    localparam logic [1:0] PivValue = 2'd0;
    localparam logic [1:0] PivMedian = 2'd1;

    typedef struct packed {
        logic signed [ValW-1:0] element;
        logic final_element;
    } t_in;

    typedef struct packed {
        logic signed [ValW-1:0] sorted_value;
        logic last_out;
        logic [SwapW-1:0] swap_count;
        logic [CallW-1:0] call_count;
    } t_out;

    typedef struct packed {
        logic [0:0] index;
        logic [1:0] data;
    } t_cfg;

    typedef enum logic [2:0] {
        OpNone,
        OpRead,
        OpWrite,
        OpPush,
        OpPop
    } t_op;

    // controller -> datapath
    typedef struct packed {
        t_op op;
        logic [IdxW-1:0] addr;
        logic signed [ValW-1:0] wdata;
        logic [2*CntW-1:0] sdata;
        logic div_start;
        logic [ValW-1:0] div_num;
        logic [CntW-1:0] div_den;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic signed [ValW-1:0] rdata;
        logic [2*CntW-1:0] sdata;
        logic [IdxW:0] sp;
        logic div_busy;
        logic [CntW-1:0] div_rem;
    } t_sts;

endpackage

FILE: rtl/core/iqs_ram.sv
module iqs_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic i_clk,
    input  logic i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0] i_wdata,
    output logic [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/core/iqs_datapath.sv
module iqs_datapath (
    input  logic i_clk,
    input  logic i_rst_n,
    input  iqs_pkg::t_cmd i_cmd,
    output iqs_pkg::t_sts o_sts
);
    import iqs_pkg::*;

    logic [IdxW:0] r_sp, n_sp;
    logic [IdxW-1:0] w_saddr;
    logic w_swe;
    logic [2*CntW-1:0] w_srd;
    logic signed [ValW-1:0] w_erd;

    // restoring divider, one quotient bit a cycle
    logic [5:0] r_dcnt;
    logic [ValW-1:0] r_dnum;
    logic [CntW-1:0] r_drem;
    logic [CntW-1:0] r_dden;
    logic [CntW:0] w_dtry;

    iqs_ram #(.Width(ValW), .Depth(MaxElements)) u_store (
        .i_clk(i_clk),
        .i_we(i_cmd.op == OpWrite),
        .i_addr(i_cmd.addr),
        .i_wdata(i_cmd.wdata),
        .o_rdata(w_erd)
    );

    assign w_swe = (i_cmd.op == OpPush) && (r_sp < (IdxW+1)'(MaxElements));
    assign w_saddr = (i_cmd.op == OpPop) ? r_sp[IdxW-1:0] - 1'b1 : r_sp[IdxW-1:0];

    iqs_ram #(.Width(2*CntW), .Depth(MaxElements)) u_stack (
        .i_clk(i_clk),
        .i_we(w_swe),
        .i_addr(w_saddr),
        .i_wdata(i_cmd.sdata),
        .o_rdata(w_srd)
    );

    always_comb begin
        n_sp = r_sp;
        if (w_swe) begin
            n_sp = r_sp + 1'b1;
        end else if (i_cmd.op == OpPop) begin
            n_sp = r_sp - 1'b1;
        end
    end

    assign w_dtry = {r_drem, r_dnum[ValW-1]} - {1'b0, r_dden};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
            r_dcnt <= '0;
        end else begin
            r_sp <= n_sp;
            if (i_cmd.div_start) begin
                r_dcnt <= 6'(ValW);
            end else if (r_dcnt != 0) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
        end
        if (i_cmd.div_start) begin
            r_dnum <= i_cmd.div_num;
            r_drem <= '0;
            r_dden <= i_cmd.div_den;
        end else if (r_dcnt != 0) begin
            r_dnum <= {r_dnum[ValW-2:0], 1'b0};
            r_drem <= w_dtry[CntW] ? {r_drem[CntW-2:0], r_dnum[ValW-1]} : w_dtry[CntW-1:0];
        end
    end

    assign o_sts.rdata = w_erd;
    assign o_sts.sdata = w_srd;
    assign o_sts.sp = r_sp;
    assign o_sts.div_busy = (r_dcnt != 0) || i_cmd.div_start;
    assign o_sts.div_rem = r_drem;
endmodule

FILE: rtl/core/iqs_ctrl.sv
module iqs_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  iqs_pkg::t_in i_in,
    input  logic i_scheme,
    input  logic [1:0] i_pivot,
    input  iqs_pkg::t_sts i_sts,
    output iqs_pkg::t_cmd o_cmd,
    output logic o_busy,
    output logic o_valid,
    output iqs_pkg::t_out o_res
);
    import iqs_pkg::*;

    localparam logic [4:0] SIdle = 5'd0;
    localparam logic [4:0] SPop = 5'd1;
    localparam logic [4:0] SPopW = 5'd2;
    localparam logic [4:0] SPivSel = 5'd3;
    localparam logic [4:0] SDiv = 5'd4;
    localparam logic [4:0] SMedA = 5'd5;
    localparam logic [4:0] SMedB = 5'd6;
    localparam logic [4:0] SMedC = 5'd7;
    localparam logic [4:0] SMedD = 5'd8;
    localparam logic [4:0] SSwRd = 5'd9;
    localparam logic [4:0] SSwA = 5'd10;
    localparam logic [4:0] SSwB = 5'd11;
    localparam logic [4:0] SSwW = 5'd12;
    localparam logic [4:0] SPivRd = 5'd13;
    localparam logic [4:0] SPivW = 5'd14;
    localparam logic [4:0] SLoop = 5'd15;
    localparam logic [4:0] SLoopW = 5'd16;
    localparam logic [4:0] SHy = 5'd17;
    localparam logic [4:0] SHyW = 5'd18;
    localparam logic [4:0] SHx = 5'd19;
    localparam logic [4:0] SHxW = 5'd20;
    localparam logic [4:0] SPushR = 5'd21;
    localparam logic [4:0] SPushL = 5'd22;
    localparam logic [4:0] SOutRd = 5'd23;
    localparam logic [4:0] SOutW = 5'd24;
    localparam logic [4:0] SValR = 5'd25;

    // swap continuation
    localparam logic [1:0] RetPiv = 2'd0;
    localparam logic [1:0] RetLoop = 2'd1;
    localparam logic [1:0] RetFin = 2'd2;
    localparam logic [1:0] RetH = 2'd3;

    logic [4:0] r_st, n_st;
    logic [CntW-1:0] r_tot, n_tot;
    logic [SwapW-1:0] r_sw, n_sw;
    logic [CallW-1:0] r_call, n_call;
    // signed loop indices (one bit wider than counts)
    logic signed [CntW:0] r_lo, n_lo, r_hi, n_hi, r_x, n_x, r_y, n_y;
    logic signed [CntW:0] r_p, n_p;
    logic signed [ValW-1:0] r_piv, n_piv, r_ta, n_ta, r_tb, n_tb;
    logic signed [ValW-1:0] r_m0, n_m0, r_m1, n_m1;
    logic [IdxW-1:0] r_sa, n_sa, r_sb, n_sb;
    logic [1:0] r_ret, n_ret;
    logic r_swp, n_swp;
    logic r_val, n_val;
    t_out r_res, n_res;
    logic [CntW-1:0] r_k, n_k;

    logic signed [CntW:0] w_len;
    logic signed [CntW+1:0] w_len3;
    logic signed [CntW:0] w_i0, w_i1, w_i2;
    logic [ValW-1:0] w_mag;

    assign w_len = r_hi - r_lo + 2'sd1;
    assign w_len3 = (CntW+2)'(w_len) * (CntW+2)'(3);
    assign w_i0 = r_lo + (w_len >>> 2);
    assign w_i1 = r_lo + (w_len >>> 1);
    assign w_i2 = r_lo + (CntW+1)'(w_len3 >>> 2);
    assign w_mag = i_sts.rdata[ValW-1] ? ValW'(-i_sts.rdata) : ValW'(i_sts.rdata);

    function automatic logic [SwapW-1:0] f_swinc(input logic [SwapW-1:0] v);
        return (v == SwapMax) ? v : v + 1'b1;
    endfunction
    function automatic logic [CallW-1:0] f_cinc(input logic [CallW-1:0] v);
        return (v == CallMax) ? v : v + 1'b1;
    endfunction

    always_comb begin
        logic signed [CntW:0] plo, phi;
        logic b01, b02, b12, b10, b20, b21;
        n_st = r_st; n_tot = r_tot; n_sw = r_sw; n_call = r_call;
        n_lo = r_lo; n_hi = r_hi; n_x = r_x; n_y = r_y; n_p = r_p;
        n_piv = r_piv; n_ta = r_ta; n_tb = r_tb; n_m0 = r_m0; n_m1 = r_m1;
        n_sa = r_sa; n_sb = r_sb; n_ret = r_ret; n_swp = r_swp;
        n_val = 1'b0; n_res = r_res; n_k = r_k;
        o_cmd = '0;
        o_cmd.op = OpNone;
        plo = '0; phi = '0;
        b01 = 1'b0; b02 = 1'b0; b12 = 1'b0; b10 = 1'b0; b20 = 1'b0; b21 = 1'b0;
        unique case (r_st)
            SIdle: begin
                if (i_start) begin
                    if (r_tot < CntW'(MaxElements)) begin
                        o_cmd.op = OpWrite;
                        o_cmd.addr = r_tot[IdxW-1:0];
                        o_cmd.wdata = i_in.element;
                        n_tot = r_tot + 1'b1;
                    end
                    if (i_in.final_element) begin
                        n_sw = '0;
                        n_call = '0;
                        n_lo = '0;
                        n_hi = (CntW+1)'(n_tot) - 2'sd1;
                        n_st = SPushL;
                    end
                end
            end
            SPop: begin
                if (i_sts.sp == 0) begin
                    n_k = '0;
                    n_st = (r_tot == 0) ? SIdle : SOutRd;
                end else begin
                    o_cmd.op = OpPop;
                    n_st = SPopW;
                end
            end
            SPopW: begin
                n_lo = (CntW+1)'(i_sts.sdata[2*CntW-1:CntW]);
                n_hi = (CntW+1)'(i_sts.sdata[CntW-1:0]) - 2'sd1;
                n_call = f_cinc(r_call);
                n_st = SPivSel;
            end
            SPivSel: begin
                if (i_pivot == PivValue) begin
                    o_cmd.op = OpRead;
                    o_cmd.addr = r_lo[IdxW-1:0];
                    n_st = SValR;
                end else if (i_pivot == PivMedian) begin
                    o_cmd.op = OpRead;
                    o_cmd.addr = w_i0[IdxW-1:0];
                    n_st = SMedA;
                end else begin
                    n_st = SPivRd;
                end
            end
            SValR: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_num = w_mag;
                o_cmd.div_den = CntW'(w_len);
                n_st = SDiv;
            end
            SDiv: begin
                if (!i_sts.div_busy) begin
                    n_p = r_lo + (CntW+1)'(i_sts.div_rem);
                    n_st = SMedD;
                end
            end
            SMedA: begin
                n_m0 = i_sts.rdata;
                o_cmd.op = OpRead;
                o_cmd.addr = w_i1[IdxW-1:0];
                n_st = SMedB;
            end
            SMedB: begin
                n_m1 = i_sts.rdata;
                o_cmd.op = OpRead;
                o_cmd.addr = w_i2[IdxW-1:0];
                n_st = SMedC;
            end
            SMedC: begin
                // keys ordered by value then slot
                b01 = (r_m0 < r_m1) || (r_m0 == r_m1);
                b02 = (r_m0 < i_sts.rdata) || (r_m0 == i_sts.rdata);
                b12 = (r_m1 < i_sts.rdata) || (r_m1 == i_sts.rdata);
                b10 = !b01; b20 = !b02; b21 = !b12;
                if ((b10 ^ b20)) begin
                    n_p = w_i0;
                end else if ((b01 ^ b21)) begin
                    n_p = w_i1;
                end else if ((b02 ^ b12)) begin
                    n_p = w_i2;
                end else begin
                    n_p = w_i1;
                end
                n_st = SMedD;
            end
            SMedD: begin
                // swap pivot into place
                n_sa = i_scheme ? r_lo[IdxW-1:0] : r_hi[IdxW-1:0];
                n_sb = r_p[IdxW-1:0];
                n_ret = RetPiv;
                n_st = SSwRd;
            end
            SSwRd: begin
                o_cmd.op = OpRead;
                o_cmd.addr = r_sa;
                n_st = SSwA;
            end
            SSwA: begin
                n_ta = i_sts.rdata;
                o_cmd.op = OpRead;
                o_cmd.addr = r_sb;
                n_st = SSwB;
            end
            SSwB: begin
                n_tb = i_sts.rdata;
                n_st = SSwW;
            end
            SSwW: begin
                if (!r_swp) begin
                    o_cmd.op = OpWrite;
                    o_cmd.addr = r_sa;
                    o_cmd.wdata = r_tb;
                    n_swp = 1'b1;
                end else begin
                    o_cmd.op = OpWrite;
                    o_cmd.addr = r_sb;
                    o_cmd.wdata = r_ta;
                    n_swp = 1'b0;
                    n_sw = f_swinc(r_sw);
                    unique case (r_ret)
                        RetPiv: n_st = SPivRd;
                        RetLoop: begin
                            n_y = r_y + 2'sd1;
                            n_st = SLoop;
                        end
                        RetFin: begin
                            n_p = r_x;
                            n_st = SPushR;
                        end
                        RetH: n_st = SHy;
                        default: n_st = SIdle;
                    endcase
                end
            end
            SPivRd: begin
                o_cmd.op = OpRead;
                o_cmd.addr = i_scheme ? r_lo[IdxW-1:0] : r_hi[IdxW-1:0];
                n_x = r_lo - 2'sd1;
                n_y = i_scheme ? r_hi + 2'sd1 : r_lo;
                n_st = SPivW;
            end
            SPivW: begin
                n_piv = i_sts.rdata;
                n_st = i_scheme ? SHy : SLoop;
            end
            SLoop: begin
                if (r_y < r_hi) begin
                    o_cmd.op = OpRead;
                    o_cmd.addr = r_y[IdxW-1:0];
                    n_st = SLoopW;
                end else begin
                    n_x = r_x + 2'sd1;
                    n_sa = n_x[IdxW-1:0];
                    n_sb = r_hi[IdxW-1:0];
                    n_ret = RetFin;
                    n_st = SSwRd;
                end
            end
            SLoopW: begin
                if (i_sts.rdata <= r_piv) begin
                    n_x = r_x + 2'sd1;
                    n_sa = n_x[IdxW-1:0];
                    n_sb = r_y[IdxW-1:0];
                    n_ret = RetLoop;
                    n_st = SSwRd;
                end else begin
                    n_y = r_y + 2'sd1;
                    n_st = SLoop;
                end
            end
            SHy: begin
                n_y = r_y - 2'sd1;
                o_cmd.op = OpRead;
                o_cmd.addr = n_y[IdxW-1:0];
                n_st = SHyW;
            end
            SHyW: begin
                if (r_y > r_lo && i_sts.rdata > r_piv) begin
                    n_y = r_y - 2'sd1;
                    o_cmd.op = OpRead;
                    o_cmd.addr = n_y[IdxW-1:0];
                end else begin
                    n_x = r_x + 2'sd1;
                    o_cmd.op = OpRead;
                    o_cmd.addr = n_x[IdxW-1:0];
                    n_st = SHxW;
                end
            end
            SHx: n_st = SHxW;
            SHxW: begin
                if (r_x < r_hi && i_sts.rdata < r_piv) begin
                    n_x = r_x + 2'sd1;
                    o_cmd.op = OpRead;
                    o_cmd.addr = n_x[IdxW-1:0];
                end else if (r_x < r_y) begin
                    n_sa = r_x[IdxW-1:0];
                    n_sb = r_y[IdxW-1:0];
                    n_ret = RetH;
                    n_st = SSwRd;
                end else begin
                    n_p = r_y;
                    n_st = SPushR;
                end
            end
            SPushR: begin
                plo = r_p + 2'sd1;
                phi = r_hi;
                if (plo >= phi) begin
                    n_call = f_cinc(r_call);
                end else begin
                    o_cmd.op = OpPush;
                    o_cmd.sdata = {CntW'(plo), CntW'(phi + 2'sd1)};
                end
                n_hi = i_scheme ? r_p : r_p - 2'sd1;
                n_st = SPushL;
            end
            SPushL: begin
                if (r_lo >= r_hi) begin
                    n_call = f_cinc(r_call);
                end else begin
                    o_cmd.op = OpPush;
                    o_cmd.sdata = {CntW'(r_lo), CntW'(r_hi + 2'sd1)};
                end
                n_st = SPop;
            end
            SOutRd: begin
                o_cmd.op = OpRead;
                o_cmd.addr = r_k[IdxW-1:0];
                n_st = SOutW;
            end
            SOutW: begin
                n_val = 1'b1;
                n_res.sorted_value = i_sts.rdata;
                n_res.last_out = (r_k + 1'b1 == r_tot);
                n_res.swap_count = r_sw;
                n_res.call_count = r_call;
                n_k = r_k + 1'b1;
                if (r_k + 1'b1 == r_tot) begin
                    n_tot = '0;
                    n_st = SIdle;
                end else begin
                    n_st = SOutRd;
                end
            end
            default: n_st = SIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SIdle;
            r_tot <= '0;
            r_sw <= '0;
            r_call <= '0;
            r_swp <= 1'b0;
            r_val <= 1'b0;
        end else begin
            r_st <= n_st;
            r_tot <= n_tot;
            r_sw <= n_sw;
            r_call <= n_call;
            r_swp <= n_swp;
            r_val <= n_val;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_x <= n_x; r_y <= n_y; r_p <= n_p;
        r_piv <= n_piv; r_ta <= n_ta; r_tb <= n_tb; r_m0 <= n_m0; r_m1 <= n_m1;
        r_sa <= n_sa; r_sb <= n_sb; r_ret <= n_ret; r_res <= n_res; r_k <= n_k;
    end

    assign o_busy = (r_st != SIdle);
    assign o_valid = r_val;
    assign o_res = r_res;
endmodule

FILE: rtl/core/instrumented_quicksort_engine.sv
// Instrumented quicksort engine.
// Input: raise start with busy low to load one element beat; a beat with
// final_element set ends the set (up to 64 kept, extras dropped) and starts
// the sort. busy stays high until the last result has gone out.
// Sorting runs on one single-port element RAM plus a range-stack RAM; each
// Lomuto compare and each Hoare scan step reads one element, and each swap
// reads both slots and writes them back. Value pivot mode adds, per
// partition, a pass through the one-bit-a-cycle remainder unit and the pivot
// swap; median mode adds three reads and the pivot swap.
// Results: beats on o_valid, in ascending order, each
// carrying the run's saturating swap and call counts; last_out marks the end.
// The receiver cannot stall: every o_valid beat is taken.
// Configuration: i_cfg_valid/o_cfg_ready write scheme (index 0) or pivot
// mode (index 1); ready is always high; the user makes writes only while idle
// and the block does not enforce it. Reset (synchronous, active low) clears
// counts, selects Lomuto with fixed end pivot, leaves the RAMs as they are.
module instrumented_quicksort_engine (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  iqs_pkg::t_in i_in,
    output logic o_valid,
    output iqs_pkg::t_out o_res,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  iqs_pkg::t_cfg i_cfg
);
    import iqs_pkg::*;

    logic r_scheme;
    logic [1:0] r_pivot;
    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme <= 1'b0;
            r_pivot <= 2'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg.index)
                CfgScheme: r_scheme <= i_cfg.data[0];
                CfgPivot: r_pivot <= i_cfg.data;
                default: r_scheme <= r_scheme;
            endcase
        end
    end

    iqs_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start && !busy),
        .i_in(i_in),
        .i_scheme(r_scheme),
        .i_pivot(r_pivot),
        .i_sts(w_sts),
        .o_cmd(w_cmd),
        .o_busy(busy),
        .o_valid(o_valid),
        .o_res(o_res)
    );

    iqs_datapath u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(w_cmd),
        .o_sts(w_sts)
    );

`ifndef SYNTHESIS
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result while idle");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last_out) |-> !busy) else $error("busy after last");
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.sp <= (IdxW+1)'(MaxElements)) else $error("stack overrun");
`endif
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import iqs_pkg::*;

    localparam int Limit = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in i_in;
    logic o_valid;
    t_out o_res;
    logic i_cfg_valid;
    logic o_cfg_ready;
    t_cfg i_cfg;

    instrumented_quicksort_engine uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_in(i_in),
        .o_valid(o_valid),
        .o_res(o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg(i_cfg)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Sort predictor: own copy of the element store, tallies and config
    // ---------------------------------------------------------------
    logic signed [ValW-1:0] shadow_store[MaxElements];
    int shadow_total;
    logic shadow_scheme;
    logic [1:0] shadow_pivot;
    int shadow_swaps;
    int shadow_calls;
    int range_lo[MaxElements];
    int range_hi[MaxElements];
    int range_sp;

    t_out sorted_q[$];   // expected result beats, oldest first

    int errors;
    int cycles;

    function automatic void tally_call();
        if (shadow_calls < int'(CallMax)) shadow_calls++;
    endfunction

    function automatic void exchange(int a, int b);
        logic signed [ValW-1:0] t;
        t = shadow_store[a];
        shadow_store[a] = shadow_store[b];
        shadow_store[b] = t;
        if (shadow_swaps < int'(SwapMax)) shadow_swaps++;
    endfunction

    // ordering by value, ties by slot position
    function automatic bit key_below(int p, int sp_, int q, int sq);
        if (shadow_store[p] != shadow_store[q]) return shadow_store[p] < shadow_store[q];
        return sp_ < sq;
    endfunction

    function automatic int choose_pivot(int lo, int hi);
        int n;
        int idx[3];
        int below;
        logic [ValW-1:0] mag;
        n = hi - lo + 1;
        if (shadow_pivot == PivValue) begin
            mag = shadow_store[lo] < 0 ? -shadow_store[lo] : shadow_store[lo];
            return lo + int'(mag % n);
        end
        if (shadow_pivot == PivMedian) begin
            idx[0] = lo + n / 4;
            idx[1] = lo + n / 2;
            idx[2] = lo + (3 * n) / 4;
            for (int k = 0; k < 3; k++) begin
                below = 0;
                for (int m = 0; m < 3; m++)
                    if (m != k && key_below(idx[m], m, idx[k], k)) below++;
                if (below == 1) return idx[k];
            end
            return idx[1];
        end
        return -1;   // fixed end element, also the unused mode three
    endfunction

    function automatic int split_range(int lo, int hi);
        int p;
        int x;
        int y;
        logic signed [ValW-1:0] piv;
        p = choose_pivot(lo, hi);
        if (shadow_scheme == 1'b0) begin
            if (p >= 0) exchange(hi, p);
            piv = shadow_store[hi];
            x = lo - 1;
            for (y = lo; y < hi; y++)
                if (shadow_store[y] <= piv) begin
                    x++;
                    exchange(x, y);
                end
            x++;
            exchange(x, hi);
            return x;
        end
        if (p >= 0) exchange(lo, p);
        piv = shadow_store[lo];
        x = lo - 1;
        y = hi + 1;
        forever begin
            do y--; while (y > lo && shadow_store[y] > piv);
            do x++; while (x < hi && shadow_store[x] < piv);
            if (x < y) exchange(x, y);
            else return y;
        end
    endfunction

    function automatic void push_span(int lo, int hi);
        if (lo >= hi) begin
            tally_call();
            return;
        end
        if (range_sp < MaxElements) begin
            range_lo[range_sp] = lo;
            range_hi[range_sp] = hi;
            range_sp++;
        end
    endfunction

    function automatic void sort_set(int n);
        int lo;
        int hi;
        int p;
        range_sp = 0;
        push_span(0, n - 1);
        while (range_sp > 0) begin
            range_sp--;
            lo = range_lo[range_sp];
            hi = range_hi[range_sp];
            tally_call();
            p = split_range(lo, hi);
            push_span(p + 1, hi);
            push_span(lo, shadow_scheme ? p : p - 1);
        end
    endfunction

    // One accepted input beat; queues the sorted run when it closes a set.
    function automatic void predict_beat(t_in beat);
        t_out r;
        if (shadow_total < MaxElements) begin
            shadow_store[shadow_total] = beat.element;
            shadow_total++;
        end
        if (!beat.final_element) return;
        shadow_swaps = 0;
        shadow_calls = 0;
        sort_set(shadow_total);
        for (int k = 0; k < shadow_total; k++) begin
            r.sorted_value = shadow_store[k];
            r.last_out = (k == shadow_total - 1);
            r.swap_count = shadow_swaps[SwapW-1:0];
            r.call_count = shadow_calls[CallW-1:0];
            sorted_q.push_back(r);
        end
        shadow_total = 0;
    endfunction

    // ---------------------------------------------------------------
    // Result checker: every strobed beat is taken at the closing edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (sorted_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", o_res);
            end else begin
                want = sorted_q.pop_front();
                if (o_res.sorted_value !== want.sorted_value ||
                    o_res.last_out !== want.last_out ||
                    o_res.swap_count !== want.swap_count ||
                    o_res.call_count !== want.call_count) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p, got %p", want, o_res);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > Limit) begin
            $display("instrumented_quicksort_engine verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    typedef struct {
        logic signed [ValW-1:0] element;
        logic final_element;
        bit typed;              // expectation typed in below
        t_out want;
    } t_row;

    localparam logic signed [31:0] VMax = 32'sh7fffffff;
    localparam logic signed [31:0] VMin = 32'sh80000000;

    // reset config: Lomuto, fixed end pivot. One-element sets: no swap, one call.
    t_row directed[] = '{
        '{VMax, 1'b1, 1'b1, '{VMax, 1'b1, 24'd0, 14'd1}},
        '{VMin, 1'b1, 1'b1, '{VMin, 1'b1, 24'd0, 14'd1}},
        '{32'sd0, 1'b1, 1'b1, '{32'sd0, 1'b1, 24'd0, 14'd1}},
        '{VMax, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{VMin, 1'b1, 1'b0, '{0, 0, 0, 0}},
        '{-32'sd1, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{32'sd5, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{32'sd5, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{VMin, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{32'sd1, 1'b1, 1'b0, '{0, 0, 0, 0}},
        '{32'sd3, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{32'sd2, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{32'sd1, 1'b1, 1'b0, '{0, 0, 0, 0}}
    };

    int burst_left;

    // Holds the beat on the port until it is taken; start is left high unless
    // a random gap is drawn, for which start is dropped.
    task automatic send_beat(t_in beat, bit typed, t_out want);
        int gap;
        i_in <= beat;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (typed) begin
            predict_beat(beat);
            void'(sorted_q.pop_back());
            sorted_q.push_back(want);
        end else begin
            predict_beat(beat);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sorted_q.size() != 0 || busy) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] index, logic [1:0] data);
        i_cfg <= '{index: index, data: data};
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index == CfgScheme) shadow_scheme = data[0];
        else shadow_pivot = data;
        @(posedge i_clk);
    endtask

    function automatic logic signed [ValW-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return VMax;
            1: return VMin;
            2, 3: return $signed($urandom_range(0, 15)) - 8;   // plenty of ties
            default: return $signed($urandom());
        endcase
    endfunction

    initial begin
        t_in beat;
        t_out none;
        int sent;
        int n;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        none = '0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg = '0;
        shadow_total = 0;
        shadow_scheme = 1'b0;
        shadow_pivot = 2'd2;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats
        foreach (directed[i]) begin
            beat.element = directed[i].element;
            beat.final_element = directed[i].final_element;
            send_beat(beat, directed[i].typed, directed[i].want);
        end
        settle();

        // random sets over every scheme / pivot mode pairing, mode three included
        sent = 0;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CfgScheme, 2'(ph / 4));
            write_reg(CfgPivot, 2'(ph % 4));
            for (int s = 0; s < 2; s++) begin
                case ($urandom_range(0, 9))
                    0: n = $urandom_range(64, 68);   // full store, extras dropped
                    1: n = $urandom_range(20, 40);
                    default: n = $urandom_range(1, 10);
                endcase
                for (int k = 0; k < n; k++) begin
                    beat.element = pick_value();
                    beat.final_element = (k == n - 1);
                    send_beat(beat, 1'b0, none);
                    sent++;
                end
            end
            settle();
        end
        write_reg(CfgScheme, 2'd0);
        write_reg(CfgPivot, 2'd2);
        while (sent < 350) begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) begin
                beat.element = pick_value();
                beat.final_element = (k == n - 1);
                send_beat(beat, 1'b0, none);
                sent++;
            end
        end
        settle();

        if (errors == 0)
            $display("instrumented_quicksort_engine verification clean");
        else
            $display("instrumented_quicksort_engine verification failed");
        $finish;
    end

endmodule
